// File: hw/rtl/ptdg_pkg.sv
package ptdg_pkg;

	// Widths of the response fields, the limit, the table entries and the program step.
	localparam int VAL_W   = 26;
	localparam int IDX_W   = 22;
	localparam int ENTRY_W = 13;
	localparam int STEP_W  = 4;

	// The limit saturates here so that all divisors up to its square root are stored.
	localparam logic [VAL_W-1:0] LIMIT_CAP = 26'd62710560;
	localparam logic [VAL_W-1:0] LIMIT_RST = 26'd1000000;

	typedef logic [3:0]        op_t;
	typedef logic [3:0]        cond_t;
	typedef logic [STEP_W-1:0] step_t;

	// Datapath operations.
	localparam op_t OP_NONE   = 4'd0;
	localparam op_t OP_ACCEPT = 4'd1;
	localparam op_t OP_TAKE   = 4'd2;
	localparam op_t OP_READ   = 4'd3;
	localparam op_t OP_SQUARE = 4'd4;
	localparam op_t OP_DIVGO  = 4'd5;
	localparam op_t OP_IDXINC = 4'd6;
	localparam op_t OP_EMITP  = 4'd7;
	localparam op_t OP_SETFIN = 4'd8;
	localparam op_t OP_EMITD  = 4'd9;

	// Jump conditions.
	localparam cond_t COND_ALWAYS  = 4'd0;
	localparam cond_t COND_ACC     = 4'd1;
	localparam cond_t COND_FIN     = 4'd2;
	localparam cond_t COND_GELIM   = 4'd3;
	localparam cond_t COND_SMALL   = 4'd4;
	localparam cond_t COND_IDXEND  = 4'd5;
	localparam cond_t COND_SQGT    = 4'd6;
	localparam cond_t COND_BUSY    = 4'd7;
	localparam cond_t COND_REMZ    = 4'd8;
	localparam cond_t COND_OUTFREE = 4'd9;

	// Program steps.
	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_FIN    = 4'd1;
	localparam step_t ST_LIM    = 4'd2;
	localparam step_t ST_TAKE   = 4'd3;
	localparam step_t ST_LOOK   = 4'd4;
	localparam step_t ST_SQ     = 4'd5;
	localparam step_t ST_DIV    = 4'd6;
	localparam step_t ST_WAIT   = 4'd7;
	localparam step_t ST_REM    = 4'd8;
	localparam step_t ST_NEXT   = 4'd9;
	localparam step_t ST_PRIME  = 4'd10;
	localparam step_t ST_RET1   = 4'd11;
	localparam step_t ST_SETFIN = 4'd12;
	localparam step_t ST_DONE   = 4'd13;
	localparam step_t ST_RET2   = 4'd14;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  inv;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic acc;
		logic fin;
		logic ge_lim;
		logic small_cand;
		logic idx_end;
		logic sq_gt;
		logic div_busy;
		logic rem_zero;
		logic out_free;
	} status_t;

	// Control store. A step jumps to its target when its condition (xor inv) holds,
	// otherwise it falls through to the following step.
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		unique case (step)
			ST_IDLE:   w = '{OP_ACCEPT, COND_ACC,     1'b1, ST_IDLE};
			ST_FIN:    w = '{OP_NONE,   COND_FIN,     1'b0, ST_DONE};
			ST_LIM:    w = '{OP_NONE,   COND_GELIM,   1'b0, ST_SETFIN};
			ST_TAKE:   w = '{OP_TAKE,   COND_SMALL,   1'b0, ST_PRIME};
			ST_LOOK:   w = '{OP_READ,   COND_IDXEND,  1'b0, ST_PRIME};
			ST_SQ:     w = '{OP_SQUARE, COND_ALWAYS,  1'b0, ST_DIV};
			ST_DIV:    w = '{OP_DIVGO,  COND_SQGT,    1'b0, ST_PRIME};
			ST_WAIT:   w = '{OP_NONE,   COND_BUSY,    1'b0, ST_WAIT};
			ST_REM:    w = '{OP_NONE,   COND_REMZ,    1'b0, ST_FIN};
			ST_NEXT:   w = '{OP_IDXINC, COND_ALWAYS,  1'b0, ST_LOOK};
			ST_PRIME:  w = '{OP_EMITP,  COND_OUTFREE, 1'b1, ST_PRIME};
			ST_RET1:   w = '{OP_NONE,   COND_ALWAYS,  1'b0, ST_IDLE};
			ST_SETFIN: w = '{OP_SETFIN, COND_ALWAYS,  1'b0, ST_DONE};
			ST_DONE:   w = '{OP_EMITD,  COND_OUTFREE, 1'b1, ST_DONE};
			ST_RET2:   w = '{OP_NONE,   COND_ALWAYS,  1'b0, ST_IDLE};
			default:   w = '{OP_NONE,   COND_ALWAYS,  1'b0, ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/ptdg_ram.sv
module ptdg_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/ptdg_rem.sv
module ptdg_rem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ptdg_pkg::VAL_W-1:0]     dividend,
	input  logic [ptdg_pkg::ENTRY_W-1:0]   divisor,
	output logic                           busy,
	output logic                           rem_zero
);
	import ptdg_pkg::*;

	localparam int CNT_W = $clog2(VAL_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [VAL_W-1:0]   dvd_q;
	logic [ENTRY_W-1:0] dvs_q;
	logic [ENTRY_W-1:0] rem_q;
	logic [ENTRY_W:0]   trial;
	logic [ENTRY_W:0]   diff;
	logic               fits;

	// Restoring division, one quotient bit per cycle; only the remainder is kept.
	assign trial = {rem_q, dvd_q[VAL_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};
	assign busy  = cnt_q != '0;
	assign rem_zero = rem_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(VAL_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? diff[ENTRY_W-1:0] : trial[ENTRY_W-1:0];
			dvd_q <= {dvd_q[VAL_W-2:0], 1'b0};
		end
	end

endmodule

// File: hw/rtl/ptdg_seq.sv
module ptdg_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  ptdg_pkg::status_t status,
	output ptdg_pkg::op_t     op
);
	import ptdg_pkg::*;

	step_t  pc_q;
	uword_t cw;
	logic   cond_hit;

	always_comb begin
		cw = ucode(pc_q);
		unique case (cw.cond)
			COND_ALWAYS:  cond_hit = 1'b1;
			COND_ACC:     cond_hit = status.acc;
			COND_FIN:     cond_hit = status.fin;
			COND_GELIM:   cond_hit = status.ge_lim;
			COND_SMALL:   cond_hit = status.small_cand;
			COND_IDXEND:  cond_hit = status.idx_end;
			COND_SQGT:    cond_hit = status.sq_gt;
			COND_BUSY:    cond_hit = status.div_busy;
			COND_REMZ:    cond_hit = status.rem_zero;
			COND_OUTFREE: cond_hit = status.out_free;
			default:      cond_hit = 1'b0;
		endcase
	end

	assign op = cw.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (cond_hit ^ cw.inv) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// File: hw/rtl/prime_trial_division_generator_unit.sv
// Each candidate is fetched through the FIN, LIM and TAKE steps. An odd one then runs LOOK, SQ
// and DIV for each stored prime tried; a divisor whose square exceeds it ends the test, else the
// 26-bit serial remainder unit runs (WAIT, REM, then NEXT if it does not divide). The word is
// registered when PRIME finds the output free. Requests are taken one at a time, the next after
// RET1 returns to IDLE; a stalled response holds the sequencer only once its next word is ready.
// Reset (arst_n low, asynchronous): limit 1000000, sequence at 2, no word pending; no table reset.
module prime_trial_division_generator_unit #(
	parameter int TABLE_PRIMES = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel: one word asks for the next prime, or restarts the sequence.
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           restart,
	// Response channel.
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [ptdg_pkg::VAL_W-1:0]     prime_value,
	output logic [ptdg_pkg::IDX_W-1:0]     prime_index,
	output logic                           done_res,
	// Limit register write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ptdg_pkg::VAL_W-1:0]     upper_limit
);
	import ptdg_pkg::*;

	localparam int AW = $clog2(TABLE_PRIMES);
	localparam int IW = AW + 1;

	op_t     op;
	status_t status;

	logic [VAL_W-1:0]   limit_q;
	logic [VAL_W-1:0]   cand_q;
	logic [VAL_W-1:0]   cur_q;
	logic [IDX_W-1:0]   count_q;
	logic               fin_q;
	logic [IW-1:0]      idx_q;
	logic [ENTRY_W-1:0] d_q;
	logic [VAL_W-1:0]   sq_q;

	logic               rsp_valid_q;
	logic [VAL_W-1:0]   prime_value_q;
	logic [IDX_W-1:0]   prime_index_q;
	logic               done_res_q;

	logic               req_acc;
	logic               out_free;
	logic               emit_prime;
	logic               emit_done;
	logic               tbl_wr;
	logic [ENTRY_W-1:0] tbl_rd_data;
	logic               div_busy;
	logic               rem_zero;
	logic [VAL_W-1:0]   cand_next;

	// The sequencer only listens for requests while it sits in its idle step.
	assign req_stall = op != OP_ACCEPT;
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	// The output register is free when empty or when its word leaves this cycle.
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign emit_prime = (op == OP_EMITP) && out_free;
	assign emit_done  = (op == OP_EMITD) && out_free;

	// Only the first TABLE_PRIMES primes are stored; later ones still go out.
	assign tbl_wr = emit_prime && (count_q < IDX_W'(TABLE_PRIMES));

	// Candidates run 2, 3, then odd numbers from 5.
	always_comb begin
		if (cand_q < VAL_W'(3)) begin
			cand_next = cand_q + VAL_W'(1);
		end else if (cand_q == VAL_W'(3)) begin
			cand_next = VAL_W'(5);
		end else begin
			cand_next = cand_q + VAL_W'(2);
		end
	end

	always_comb begin
		status.acc        = req_acc;
		status.fin        = fin_q;
		status.ge_lim     = cand_q >= limit_q;
		status.small_cand = cand_q < VAL_W'(5);
		// Trial division stops when the stored primes run out: the index has reached
		// the number of primes found so far or the end of the table.
		status.idx_end    = ({{(IDX_W-IW){1'b0}}, idx_q} >= count_q) ||
			(idx_q >= IW'(TABLE_PRIMES));
		status.sq_gt      = sq_q > cur_q;
		status.div_busy   = div_busy;
		status.rem_zero   = rem_zero;
		status.out_free   = out_free;
	end

	ptdg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	ptdg_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_PRIMES)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (cur_q[ENTRY_W-1:0]),
		.rd_en   (op == OP_READ),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (tbl_rd_data)
	);

	ptdg_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (op == OP_DIVGO),
		.dividend (cur_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.rem_zero (rem_zero)
	);

	// Limit register; values above the cap are stored as the cap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= (upper_limit > LIMIT_CAP) ? LIMIT_CAP : upper_limit;
		end
	end

	// Sequence state: next candidate, primes given so far, and the sticky done flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q  <= VAL_W'(2);
			count_q <= '0;
			fin_q   <= 1'b0;
		end else begin
			if (req_acc && restart) begin
				cand_q  <= VAL_W'(2);
				count_q <= '0;
				fin_q   <= 1'b0;
			end
			if (op == OP_TAKE) begin
				cand_q <= cand_next;
			end
			if (op == OP_SETFIN) begin
				fin_q <= 1'b1;
			end
			if (emit_prime && (count_q != {IDX_W{1'b1}})) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Working registers of one candidate test.
	always_ff @(posedge clk) begin
		if (op == OP_TAKE) begin
			cur_q <= cand_q;
			idx_q <= IW'(1);
		end
		if (op == OP_IDXINC) begin
			idx_q <= idx_q + 1'b1;
		end
		if (op == OP_SQUARE) begin
			d_q  <= tbl_rd_data;
			sq_q <= VAL_W'(tbl_rd_data) * VAL_W'(tbl_rd_data);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_prime || emit_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_prime) begin
			prime_value_q <= cur_q;
			prime_index_q <= count_q;
			done_res_q    <= 1'b0;
		end else if (emit_done) begin
			prime_value_q <= '0;
			prime_index_q <= count_q;
			done_res_q    <= 1'b1;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign prime_value = prime_value_q;
	assign prime_index = prime_index_q;
	assign done_res    = done_res_q;

endmodule

// File: hw/rtl/ptdg_chk.sv
module ptdg_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_stall,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input logic [ptdg_pkg::VAL_W-1:0]     prime_value,
	input logic [ptdg_pkg::IDX_W-1:0]     prime_index,
	input logic                           done_res
);

	// A done word carries no prime.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> prime_value == '0)
		else $error("done word with nonzero prime value");

	// A prime word never carries a value below two.
	a_prime_min: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !done_res |-> prime_value >= 2)
		else $error("prime word below two");

	// After a request is taken the unit is busy and takes no second word at once.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken in two consecutive cycles");

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(prime_value) &&
			$stable(prime_index) && $stable(done_res))
		else $error("stalled response word changed");

endmodule

bind prime_trial_division_generator_unit ptdg_chk u_ptdg_chk (.*);
